>>> design/kns_pkg.sv
// shared constants, types and series denominator functions of the kepler newton solver
`default_nettype none
package kns_pkg;

	localparam int PHI_W = 60;
	localparam int DEN_W = 9;
	localparam int TAYLOR_TERMS = 11;

	localparam logic signed [63:0] ONE_Q        = 64'sh0100_0000_0000_0000;
	localparam logic signed [63:0] TWO_PI_Q     = 64'sh0648_7ED5_110B_4612;
	localparam logic signed [63:0] HALF_PI_Q    = 64'sh0192_1FB5_4442_D184;
	localparam logic signed [63:0] QUARTER_PI_Q = 64'sh00C9_0FDA_A221_68C2;
	localparam logic signed [63:0] PSI_LIM      = 64'sh2000_0000_0000_0000;

	localparam logic [1:0] CFG_ECC   = 2'd0;
	localparam logic [1:0] CFG_TOL   = 2'd1;
	localparam logic [1:0] CFG_MAXIT = 2'd2;

	typedef struct packed {
		logic               start;
		logic signed [63:0] a;
		logic signed [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic        start;
		logic [63:0] n;
		logic [56:0] d;
	} div_req_t;

	function automatic logic [DEN_W-1:0] sin_den(input logic [3:0] n);
		logic [DEN_W-1:0] v;
		v = DEN_W'({5'd0, n, 1'b0} * {5'd0, n, 1'b1});
		return v;
	endfunction

	function automatic logic [DEN_W-1:0] cos_den(input logic [3:0] n);
		logic [DEN_W-1:0] v;
		v = DEN_W'(({5'd0, n, 1'b0} - 10'd1) * {5'd0, n, 1'b0});
		return v;
	endfunction

endpackage
`default_nettype wire

>>> design/kns_front.sv
// front end: takes mean anomalies and reduces them modulo two pi
`default_nettype none
module kns_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic signed [31:0]              mean_anomaly,
	output logic                                 busy,
	input  wire logic                            full,
	output logic                                 push,
	output logic signed [kns_pkg::PHI_W-1:0]     phi
);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_RED  = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	fstate_t     state_q;
	logic        neg_q;
	logic [63:0] dvd_q;
	logic [2:0]  j_q;
	logic [63:0] step_c;
	logic [31:0] mag_c;
	logic [kns_pkg::PHI_W-1:0] rem_c;

	assign busy   = (state_q != F_IDLE);
	assign push   = (state_q == F_PUSH) && !full;
	assign step_c = 64'(kns_pkg::TWO_PI_Q) << j_q;
	assign mag_c  = mean_anomaly[31] ? (~mean_anomaly + 32'd1) : mean_anomaly;
	assign rem_c  = {1'b0, dvd_q[kns_pkg::PHI_W-2:0]};
	assign phi    = neg_q ? -$signed(rem_c) : $signed(rem_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: if (start) state_q <= F_RED;
				F_RED:  if (j_q == 3'd0) state_q <= F_PUSH;
				F_PUSH: if (!full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && start) begin
			neg_q <= mean_anomaly[31];
			dvd_q <= {mag_c, 32'd0};
			j_q   <= 3'd5;
		end else if (state_q == F_RED) begin
			if (dvd_q >= step_c) dvd_q <= dvd_q - step_c;
			if (j_q != 3'd0) j_q <= j_q - 3'd1;
		end
	end

endmodule
`default_nettype wire

>>> design/kns_queue.sv
// two-entry queue of reduced anomalies between front and back
`default_nettype none
module kns_queue (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	input  wire logic signed [kns_pkg::PHI_W-1:0] wdata,
	input  wire logic                            pop,
	output logic signed [kns_pkg::PHI_W-1:0]     rdata,
	output logic                                 full,
	output logic                                 empty
);

	logic signed [kns_pkg::PHI_W-1:0] ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= wdata;
	end

endmodule
`default_nettype wire

>>> design/kns_mul.sv
// q56 multiplier, four 32x32 partial products accumulated in turn
`default_nettype none
module kns_mul (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire kns_pkg::mul_req_t req,
	output logic                   done,
	output logic signed [63:0]     p
);

	logic         busy_q;
	logic         done_q;
	logic [1:0]   cnt_q;
	logic [63:0]  ua_q;
	logic [63:0]  ub_q;
	logic         neg_q;
	logic [127:0] acc_q;
	logic [31:0]  opa_c;
	logic [31:0]  opb_c;
	logic [63:0]  pp_c;
	logic [127:0] sh_c;
	logic [62:0]  m_c;

	assign opa_c = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
	assign opb_c = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
	assign pp_c  = opa_c * opb_c;

	always_comb begin
		unique case (cnt_q)
			2'd0:    sh_c = 128'(pp_c);
			2'd3:    sh_c = 128'(pp_c) << 64;
			default: sh_c = 128'(pp_c) << 32;
		endcase
	end

	assign m_c  = acc_q[118:56];
	assign p    = neg_q ? -$signed({1'b0, m_c}) : $signed({1'b0, m_c});
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= busy_q && (cnt_q == 2'd3);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			ua_q  <= req.a[63] ? 64'(-req.a) : 64'(req.a);
			ub_q  <= req.b[63] ? 64'(-req.b) : 64'(req.b);
			neg_q <= req.a[63] ^ req.b[63];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + sh_c;
		end
	end

endmodule
`default_nettype wire

>>> design/kns_div.sv
// newton step divider, one quotient bit a cycle, quotient capped at 2^61
`default_nettype none
module kns_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire kns_pkg::div_req_t req,
	output logic                   done,
	output logic [61:0]            q
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [56:0] d_q;
	logic [56:0] r_q;
	logic [60:0] num_q;
	logic [61:0] q_q;
	logic [57:0] r2_c;
	logic        ge_c;
	logic [57:0] rn_c;
	logic        cap_c;

	assign cap_c = req.n >= {2'b00, req.d, 5'd0};
	assign r2_c  = {r_q, num_q[60]};
	assign ge_c  = r2_c >= {1'b0, d_q};
	assign rn_c  = ge_c ? (r2_c - {1'b0, d_q}) : r2_c;
	assign done  = done_q;
	assign q     = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= 6'd60;
				if (cap_c) done_q <= 1'b1;
				else busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			d_q   <= req.d;
			r_q   <= req.n[61:5];
			num_q <= {req.n[4:0], 56'd0};
			q_q   <= cap_c ? 62'(kns_pkg::PSI_LIM) : '0;
		end else if (busy_q) begin
			r_q   <= rn_c[56:0];
			num_q <= {num_q[59:0], 1'b0};
			q_q   <= {q_q[60:0], ge_c};
		end
	end

endmodule
`default_nettype wire

>>> design/kns_back.sv
// back end: newton iteration with series sine and cosine on shared units
`default_nettype none
module kns_back #(
	parameter int OUT_SHIFT = 28
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             q_empty,
	input  wire logic signed [kns_pkg::PHI_W-1:0] q_phi,
	output logic                                  q_pop,
	input  wire logic [30:0]                      eccentricity,
	input  wire logic [28:0]                      tolerance,
	input  wire logic [5:0]                       max_iterations,
	output logic                                  done,
	output logic signed [31:0]                    eccentric_anomaly,
	output logic [5:0]                            steps_used,
	output logic                                  converged
);

	typedef enum logic [14:0] {
		B_IDLE = 15'h0001,
		B_TADD = 15'h0002,
		B_RED  = 15'h0004,
		B_FIX  = 15'h0008,
		B_X2   = 15'h0010,
		B_MS   = 15'h0020,
		B_DS   = 15'h0040,
		B_MC   = 15'h0080,
		B_DC   = 15'h0100,
		B_FIN  = 15'h0200,
		B_ES   = 15'h0400,
		B_CHK  = 15'h0800,
		B_EC   = 15'h1000,
		B_QD   = 15'h2000,
		B_OUT  = 15'h4000
	} bstate_t;

	bstate_t state_q;
	logic    wait_q;
	logic    done_q;

	logic signed [kns_pkg::PHI_W-1:0] phi_q;
	logic signed [63:0] psi_q, x_q, x2_q, ts_q, tc_q, s_q, c_q, sv_q, cv_q, res_q;
	logic [5:0]  steps_q;
	logic [63:0] redm_q;
	logic [4:0]  redk_q;
	logic        redneg_q;
	logic [2:0]  redj_q;
	logic [3:0]  n_q;
	logic [1:0]  quad_q;
	logic [56:0] d_q;
	logic [63:0] sd_q;
	logic [kns_pkg::DEN_W-1:0] sr_q;
	logic [2:0]  scnt_q;
	logic        sneg_q;
	logic        conv_q;
	logic signed [31:0] ea_q;
	logic [5:0]  su_q;

	kns_pkg::mul_req_t mreq;
	kns_pkg::div_req_t dreq;
	logic               mul_done;
	logic signed [63:0] mul_p;
	logic               div_done;
	logic [61:0]        div_q;

	logic signed [63:0] e56_c, t_c, hstep_c, rem_c, x_c, term_c, scl_c, ccl_c;
	logic signed [63:0] psin_c, rr_c;
	logic [63:0] tolv_c, resm_c, pm_c;
	logic        tovf_c;
	logic [1:0]  kl_c;
	logic [kns_pkg::DEN_W-1:0] den_c;
	logic [63:0] sd_n;
	logic [kns_pkg::DEN_W-1:0] sr_n;
	logic        mul_st, div_st;

	kns_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .done(mul_done), .p(mul_p));
	kns_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .done(div_done), .q(div_q));

	assign e56_c   = $signed({8'd0, eccentricity, 25'd0});
	assign t_c     = psi_q + kns_pkg::QUARTER_PI_Q;
	assign hstep_c = kns_pkg::HALF_PI_Q <<< redj_q;
	assign tovf_c  = |(64'(tolerance) >> (63 - OUT_SHIFT));
	assign tolv_c  = tovf_c ? '1 : (64'(tolerance) << OUT_SHIFT);
	assign resm_c  = res_q[63] ? 64'(-res_q) : 64'(res_q);
	assign pm_c    = mul_p[63] ? 64'(-mul_p) : 64'(mul_p);

	always_comb begin
		if (!redneg_q) begin
			rem_c = $signed(redm_q);
			kl_c  = redk_q[1:0];
		end else if (redm_q == 64'd0) begin
			rem_c = '0;
			kl_c  = ~redk_q[1:0] + 2'd1;
		end else begin
			rem_c = kns_pkg::HALF_PI_Q - $signed(redm_q);
			kl_c  = ~redk_q[1:0];
		end
	end
	assign x_c = rem_c - kns_pkg::QUARTER_PI_Q;

	// small divider for the series terms, eight quotient bits a cycle
	always_comb begin
		logic [kns_pkg::DEN_W:0] r2;
		logic [kns_pkg::DEN_W-1:0] r;
		logic [63:0] dv;
		r   = sr_q;
		dv  = sd_q;
		den_c = (state_q == B_DS) ? kns_pkg::sin_den(n_q) : kns_pkg::cos_den(n_q);
		for (int i = 0; i < 8; i++) begin
			r2 = {r, dv[63]};
			dv = {dv[62:0], 1'b0};
			if (r2 >= {1'b0, den_c}) begin
				r2    = r2 - {1'b0, den_c};
				dv[0] = 1'b1;
			end
			r = r2[kns_pkg::DEN_W-1:0];
		end
		sd_n = dv;
		sr_n = r;
	end
	assign term_c = sneg_q ? $signed(sd_n) : -$signed(sd_n);

	always_comb begin
		if (s_q > kns_pkg::ONE_Q) scl_c = kns_pkg::ONE_Q;
		else if (s_q < -kns_pkg::ONE_Q) scl_c = -kns_pkg::ONE_Q;
		else scl_c = s_q;
		if (c_q > kns_pkg::ONE_Q) ccl_c = kns_pkg::ONE_Q;
		else if (c_q < -kns_pkg::ONE_Q) ccl_c = -kns_pkg::ONE_Q;
		else ccl_c = c_q;
	end

	always_comb begin
		logic signed [63:0] pn;
		pn = res_q[63] ? (psi_q + $signed({2'b00, div_q})) : (psi_q - $signed({2'b00, div_q}));
		if (pn > kns_pkg::PSI_LIM) psin_c = kns_pkg::PSI_LIM;
		else if (pn < -kns_pkg::PSI_LIM) psin_c = -kns_pkg::PSI_LIM;
		else psin_c = pn;
	end

	assign rr_c = (psi_q + (64'sd1 <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;

	assign mul_st = !wait_q && ((state_q == B_X2) || (state_q == B_MS) || (state_q == B_MC)
		|| (state_q == B_ES) || (state_q == B_EC));
	assign div_st = !wait_q && (state_q == B_QD);

	always_comb begin
		mreq.start = mul_st;
		unique case (state_q)
			B_X2:    begin mreq.a = x_q;   mreq.b = x_q;  end
			B_MS:    begin mreq.a = ts_q;  mreq.b = x2_q; end
			B_MC:    begin mreq.a = tc_q;  mreq.b = x2_q; end
			B_ES:    begin mreq.a = e56_c; mreq.b = sv_q; end
			default: begin mreq.a = e56_c; mreq.b = cv_q; end
		endcase
		dreq.start = div_st;
		dreq.n     = resm_c;
		dreq.d     = d_q;
	end

	assign q_pop             = (state_q == B_IDLE) && !q_empty;
	assign done              = done_q;
	assign eccentric_anomaly = ea_q;
	assign steps_used        = su_q;
	assign converged         = conv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			wait_q  <= 1'b0;
			done_q  <= 1'b0;
			redj_q  <= 3'd0;
			n_q     <= 4'd0;
			scnt_q  <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (mul_st || div_st) wait_q <= 1'b1;
			else if (mul_done || div_done) wait_q <= 1'b0;
			unique case (state_q)
				B_IDLE: if (!q_empty) state_q <= B_TADD;
				B_TADD: begin
					redj_q  <= 3'd4;
					state_q <= B_RED;
				end
				B_RED: begin
					if (redj_q == 3'd0) state_q <= B_FIX;
					else redj_q <= redj_q - 3'd1;
				end
				B_FIX: begin
					n_q     <= 4'd1;
					state_q <= B_X2;
				end
				B_X2: if (mul_done) state_q <= B_MS;
				B_MS: if (mul_done) begin
					scnt_q  <= 3'd0;
					state_q <= B_DS;
				end
				B_DS: begin
					scnt_q <= scnt_q + 3'd1;
					if (scnt_q == 3'd7) state_q <= B_MC;
				end
				B_MC: if (mul_done) begin
					scnt_q  <= 3'd0;
					state_q <= B_DC;
				end
				B_DC: begin
					scnt_q <= scnt_q + 3'd1;
					if (scnt_q == 3'd7) begin
						if (n_q == 4'(kns_pkg::TAYLOR_TERMS)) state_q <= B_FIN;
						else begin
							n_q     <= n_q + 4'd1;
							state_q <= B_MS;
						end
					end
				end
				B_FIN: state_q <= B_ES;
				B_ES:  if (mul_done) state_q <= B_CHK;
				B_CHK: begin
					if (resm_c <= tolv_c || steps_q >= max_iterations) state_q <= B_OUT;
					else state_q <= B_EC;
				end
				B_EC: if (mul_done) state_q <= B_QD;
				B_QD: if (div_done) state_q <= B_TADD;
				B_OUT: begin
					done_q  <= 1'b1;
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				phi_q   <= q_phi;
				psi_q   <= 64'(q_phi);
				steps_q <= 6'd0;
			end
			B_TADD: begin
				redneg_q <= t_c[63];
				redm_q   <= t_c[63] ? 64'(-t_c) : 64'(t_c);
				redk_q   <= 5'd0;
			end
			B_RED: begin
				if (redm_q >= 64'(hstep_c)) begin
					redm_q         <= redm_q - 64'(hstep_c);
					redk_q[redj_q] <= 1'b1;
				end
			end
			B_FIX: begin
				x_q    <= x_c;
				ts_q   <= x_c;
				s_q    <= x_c;
				tc_q   <= kns_pkg::ONE_Q;
				c_q    <= kns_pkg::ONE_Q;
				quad_q <= kl_c;
			end
			B_X2: if (mul_done) x2_q <= mul_p;
			B_MS, B_MC: if (mul_done) begin
				sd_q   <= pm_c;
				sr_q   <= '0;
				sneg_q <= mul_p[63];
			end
			B_DS: begin
				sd_q <= sd_n;
				sr_q <= sr_n;
				if (scnt_q == 3'd7) begin
					ts_q <= term_c;
					s_q  <= s_q + term_c;
				end
			end
			B_DC: begin
				sd_q <= sd_n;
				sr_q <= sr_n;
				if (scnt_q == 3'd7) begin
					tc_q <= term_c;
					c_q  <= c_q + term_c;
				end
			end
			B_FIN: begin
				unique case (quad_q)
					2'd0: begin sv_q <= scl_c;  cv_q <= ccl_c;  end
					2'd1: begin sv_q <= ccl_c;  cv_q <= -scl_c; end
					2'd2: begin sv_q <= -scl_c; cv_q <= -ccl_c; end
					default: begin sv_q <= -ccl_c; cv_q <= scl_c; end
				endcase
			end
			B_ES: if (mul_done) res_q <= psi_q - mul_p - 64'(phi_q);
			B_CHK: conv_q <= (resm_c <= tolv_c);
			B_EC: if (mul_done) d_q <= 57'(kns_pkg::ONE_Q - mul_p);
			B_QD: if (div_done) begin
				psi_q   <= psin_c;
				steps_q <= steps_q + 6'd1;
			end
			B_OUT: begin
				su_q <= steps_q;
				if (rr_c > 64'sd2147483647) ea_q <= 32'sh7FFF_FFFF;
				else if (rr_c < -64'sd2147483648) ea_q <= 32'sh8000_0000;
				else ea_q <= rr_c[31:0];
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

>>> design/kepler_newton_solver.sv
// top level of the kepler equation newton solver
//
// channel    direction  signals                                       transfer when
// command    in         start, mean_anomaly, busy                     start && !busy
// result     out        done, eccentric_anomaly, steps_used, converged done high, one cycle
// config     in         cfg_we, cfg_index, cfg_data                   cfg_we high
//
// front reduces modulo two pi and hands over through a two-entry queue
// each residual evaluation runs 11 series terms on the shared multiplier, which sums four
// partial products, and the term divider; each newton update adds a 61-bit divide
// an item takes one residual evaluation, plus one evaluation and one update per step in steps_used
// reset clears control and loads register defaults; results cannot be held off
`default_nettype none
module kepler_newton_solver #(
	parameter int ANGLE_FRAC_BITS = 28
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] mean_anomaly,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [30:0]        cfg_data,
	output logic                    done,
	output logic signed [31:0]      eccentric_anomaly,
	output logic [5:0]              steps_used,
	output logic                    converged
);

	localparam int OUT_SHIFT = 56 - ANGLE_FRAC_BITS;

	logic [30:0] ecc_q;
	logic [28:0] tol_q;
	logic [5:0]  maxit_q;

	logic                             push;
	logic signed [kns_pkg::PHI_W-1:0] phi_w;
	logic signed [kns_pkg::PHI_W-1:0] qd_w;
	logic                             full;
	logic                             empty;
	logic                             pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ecc_q   <= 31'd0;
			tol_q   <= 29'd268;
			maxit_q <= 6'd32;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kns_pkg::CFG_ECC:   ecc_q   <= cfg_data;
				kns_pkg::CFG_TOL:   tol_q   <= cfg_data[28:0];
				kns_pkg::CFG_MAXIT: maxit_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	kns_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .mean_anomaly(mean_anomaly),
		.busy(busy), .full(full), .push(push), .phi(phi_w)
	);

	kns_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(phi_w), .pop(pop),
		.rdata(qd_w), .full(full), .empty(empty)
	);

	kns_back #(.OUT_SHIFT(OUT_SHIFT)) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(empty), .q_phi(qd_w), .q_pop(pop),
		.eccentricity(ecc_q), .tolerance(tol_q), .max_iterations(maxit_q),
		.done(done), .eccentric_anomaly(eccentric_anomaly), .steps_used(steps_used),
		.converged(converged)
	);

endmodule
`default_nettype wire

>>> test/tb_top.sv
// self-checking testbench of the kepler newton solver with its own fixed-point solver
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

	localparam logic [1:0] CFG_SPARE = 2'd3;
	localparam longint unsigned PSI_CAP = 64'h2000_0000_0000_0000;

	typedef struct {
		logic signed [31:0] anomaly;
		logic [5:0]         steps;
		logic               conv;
	} solution_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [31:0] mean_anomaly = '0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [30:0] cfg_data = '0;
	logic busy, done, converged;
	logic signed [31:0] eccentric_anomaly;
	logic [5:0] steps_used;

	logic [30:0] ecc_shadow = 31'd0;
	logic [28:0] tol_shadow = 29'd268;
	logic [5:0]  cap_shadow = 6'd32;

	logic signed [31:0] anomaly_queue[$];
	solution_t solution_queue[$];
	int idle_pct = 6;
	int mismatches = 0;

	kepler_newton_solver DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.mean_anomaly(mean_anomaly), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .eccentric_anomaly(eccentric_anomaly),
		.steps_used(steps_used), .converged(converged)
	);

	function automatic longint unsigned magnitude(input longint v);
		return v < 0 ? 64'd0 - 64'(v) : 64'(v);
	endfunction

	function automatic longint fix_mul(input longint a, input longint b);
		logic [127:0] p;
		logic [63:0] m;
		p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
		m = p[119:56];
		m[63] = 1'b0;
		return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint unsigned fix_div(input longint unsigned n,
			input longint unsigned d);
		logic [127:0] q;
		q = {8'd0, n, 56'd0} / {64'd0, d};
		return (q > PSI_CAP) ? PSI_CAP : q[63:0];
	endfunction

	task automatic sin_cos(input longint a, output longint s_out, output longint c_out);
		longint t, k, x, x2, ts, tc, s, c, n;
		t = a + kns_pkg::QUARTER_PI_Q;
		k = t / kns_pkg::HALF_PI_Q;
		if (t - k * kns_pkg::HALF_PI_Q < 0)
			k--;
		x = a - k * kns_pkg::HALF_PI_Q;
		x2 = fix_mul(x, x);
		ts = x; s = x; tc = kns_pkg::ONE_Q; c = kns_pkg::ONE_Q;
		for (n = 1; n <= 11; n++) begin
			ts = -fix_mul(ts, x2) / ((2 * n) * (2 * n + 1));
			tc = -fix_mul(tc, x2) / ((2 * n - 1) * (2 * n));
			s += ts;
			c += tc;
		end
		if (s > kns_pkg::ONE_Q) s = kns_pkg::ONE_Q;
		if (s < -kns_pkg::ONE_Q) s = -kns_pkg::ONE_Q;
		if (c > kns_pkg::ONE_Q) c = kns_pkg::ONE_Q;
		if (c < -kns_pkg::ONE_Q) c = -kns_pkg::ONE_Q;
		case (k[1:0])
			2'd0: begin s_out = s; c_out = c; end
			2'd1: begin s_out = c; c_out = -s; end
			2'd2: begin s_out = -s; c_out = -c; end
			default: begin s_out = -c; c_out = s; end
		endcase
	endtask

	task automatic solve_kepler(input logic signed [31:0] m_in, output solution_t sol);
		longint unsigned mag, rem, tol, q, u;
		longint phi, e56, psi, s, c, res, d, r;
		int steps;
		logic conv;
		mag = (m_in < 0) ? 64'h1_0000_0000 - {32'd0, m_in} : {32'd0, m_in};
		rem = (mag << 32) % 64'(kns_pkg::TWO_PI_Q);
		phi = (m_in < 0) ? -longint'(rem) : longint'(rem);
		e56 = longint'({33'd0, ecc_shadow} << 25);
		tol = ((64'(tol_shadow) >> 35) != 0) ? '1 : 64'(tol_shadow) << 28;
		psi = phi;
		steps = 0;
		conv = 1'b0;
		forever begin
			sin_cos(psi, s, c);
			res = psi - fix_mul(e56, s) - phi;
			if (magnitude(res) <= tol) begin
				conv = 1'b1;
				break;
			end
			if (steps >= cap_shadow)
				break;
			d = kns_pkg::ONE_Q - fix_mul(e56, c);
			q = fix_div(magnitude(res), 64'(d));
			psi = (res < 0) ? psi + longint'(q) : psi - longint'(q);
			if (psi > kns_pkg::PSI_LIM) psi = kns_pkg::PSI_LIM;
			if (psi < -kns_pkg::PSI_LIM) psi = -kns_pkg::PSI_LIM;
			steps++;
		end
		u = 64'(psi) + 64'h8000_0000_0000_0000 + 64'h0800_0000;
		r = longint'(u >> 28) - longint'(64'h8000_0000_0000_0000 >> 28);
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		sol.anomaly = r[31:0];
		sol.steps = 6'(steps);
		sol.conv = conv;
	endtask

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#(2.0e9);
		$display("Simulation FAILED");
		$finish;
	end

	// command driver
	always @(posedge clk) begin
		solution_t sol;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!(start && busy)) begin
			if (start) begin
				solve_kepler(mean_anomaly, sol);
				solution_queue.push_back(sol);
			end
			if (anomaly_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
				start <= 1'b1;
				mean_anomaly <= anomaly_queue.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		solution_t exp_sol;
		if (arst_n && done) begin
			if (solution_queue.size() == 0) begin
				$error("result transfer with nothing expected");
				mismatches++;
			end else begin
				exp_sol = solution_queue.pop_front();
				if (eccentric_anomaly !== exp_sol.anomaly) begin
					$error("eccentric_anomaly expected %0d actual %0d",
						exp_sol.anomaly, eccentric_anomaly);
					mismatches++;
				end
				if (steps_used !== exp_sol.steps) begin
					$error("steps_used expected %0d actual %0d", exp_sol.steps, steps_used);
					mismatches++;
				end
				if (converged !== exp_sol.conv) begin
					$error("converged expected %0d actual %0d", exp_sol.conv, converged);
					mismatches++;
				end
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [30:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			kns_pkg::CFG_ECC:   ecc_shadow = data;
			kns_pkg::CFG_TOL:   tol_shadow = data[28:0];
			kns_pkg::CFG_MAXIT: cap_shadow = data[5:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (anomaly_queue.size() > 0 || start || busy || solution_queue.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_regs(input logic [30:0] ecc, input logic [30:0] tol,
			input logic [30:0] cap);
		wait_idle();
		write_reg(kns_pkg::CFG_ECC, ecc);
		write_reg(kns_pkg::CFG_TOL, tol);
		write_reg(kns_pkg::CFG_MAXIT, cap);
	endtask

	function automatic logic signed [31:0] random_anomaly();
		case ($urandom_range(3))
			0: return $signed($urandom_range(210828714));
			1: return -$signed($urandom_range(210828714));
			default: return $signed($urandom);
		endcase
	endfunction

	initial begin
		logic [30:0] ecc, tol, cap;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default registers: zero eccentricity, range extremes and multiples of half pi
		write_reg(CFG_SPARE, 31'h7fffffff);
		anomaly_queue = '{32'sd0, 32'sd1, -32'sd1, 32'sh7fffffff, 32'sh80000000,
			32'sd105414357, -32'sd105414357, 32'sd52707179, 32'sd26353589};
		set_regs(31'h7fffffff, 31'd0, 31'd0);
		anomaly_queue = '{32'sd0, 32'sd26353589, -32'sh7fffffff, 32'sh80000000};
		set_regs(31'h7fffffff, 31'd0, 31'd63);
		anomaly_queue = '{32'sd3, -32'sd52707179};
		set_regs(31'h7fffffff, 31'd268435456, 31'd63);
		anomaly_queue = '{32'sd40000000, 32'sh80000000};
		set_regs(31'h7fffffff, 31'd1, 31'd12);
		anomaly_queue = '{32'sd1000, -32'sd70000000, 32'sh7fffffff};

		for (int phase = 0; phase < 10; phase++) begin
			case (phase)
				0: begin ecc = 31'd0; tol = 31'd268; cap = 31'd32; end
				1: begin ecc = 31'h7fffffff; tol = 31'd268; cap = 31'd8; end
				2: begin ecc = 31'h40000000; tol = 31'd1; cap = 31'd16; end
				3: begin ecc = 31'h7fffffff; tol = 31'd0; cap = 31'd4; end
				4: begin ecc = 31'($urandom); tol = 31'd268435456; cap = 31'd63; end
				5: begin
					ecc = 31'($urandom); tol = 31'($urandom_range(4095)); cap = 31'd0;
				end
				6: begin ecc = 31'h73333333; tol = 31'd1000; cap = 31'd63; end
				7: begin
					ecc = 31'($urandom);
					tol = 31'($urandom_range(1 << 20, 1));
					cap = 31'($urandom_range(63, 1));
				end
				8: begin ecc = 31'h0ccccccc; tol = 31'd268; cap = 31'd1; end
				default: begin
					ecc = 31'($urandom); tol = 31'($urandom); cap = 31'($urandom_range(12));
				end
			endcase
			set_regs(ecc, tol, cap);
			idle_pct = (phase < 4) ? 6 : ((phase < 7) ? 87 : 0);
			for (int i = 0; i < 150; i++)
				anomaly_queue.push_back(random_anomaly());
		end

		wait_idle();
		repeat (50) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire
